@@ hw/rtl/tce_pkg.sv @@
// shared types and constants of the text console engine
package tce_pkg;

    // field widths of the channels
    localparam int OP_W       = 1;
    localparam int CHAR_W     = 8;
    localparam int RROW_W     = 5;
    localparam int RCOL_W     = 7;
    localparam int CELL_W     = 16;
    localparam int OROW_W     = 5;
    localparam int OCOL_W     = 7;
    localparam int OIDX_W     = 11;
    localparam int COLOR_W    = 4;
    localparam int CFG_IDX_W  = 2;

    // operations
    localparam logic [OP_W-1:0] OP_PUT  = 1'b0;
    localparam logic [OP_W-1:0] OP_READ = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FG_IDX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_IDX = 2'd1;

    // colour reset values
    localparam logic [COLOR_W-1:0] RESET_FG = 4'd7;
    localparam logic [COLOR_W-1:0] RESET_BG = 4'd0;

    // character codes
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    // sequencer states
    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_RDWAIT,
        S_SWEEP,
        S_RESULT
    } tce_state_t;

    // one result item
    typedef struct packed {
        logic [CELL_W-1:0] cell_value;
        logic [OROW_W-1:0] cursor_row;
        logic [OCOL_W-1:0] cursor_col;
        logic [OIDX_W-1:0] cursor_index;
    } out_item_t;

endpackage

@@ hw/rtl/tce_if.sv @@
// channel interfaces of the text console engine: command, response, register write
interface tce_cmd_if
    import tce_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] char_code;
    logic [RROW_W-1:0] read_row;
    logic [RCOL_W-1:0] read_col;

    modport source (output valid, op, char_code, read_row, read_col, input ready);
    modport sink   (input valid, op, char_code, read_row, read_col, output ready);
endinterface

interface tce_rsp_if
    import tce_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CELL_W-1:0] cell_value;
    logic [OROW_W-1:0] cursor_row;
    logic [OCOL_W-1:0] cursor_col;
    logic [OIDX_W-1:0] cursor_index;

    modport source (output valid, cell_value, cursor_row, cursor_col, cursor_index,
                    input ready);
    modport sink   (input valid, cell_value, cursor_row, cursor_col, cursor_index,
                    output ready);
endinterface

interface tce_cfg_if
    import tce_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [COLOR_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/tce_screen_ram.sv @@
// screen cell memory, write and read enables on one shared address, registered read data
module tce_screen_ram
    import tce_pkg::*;
#(
    parameter  int DEPTH = 2000,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [AW-1:0]     addr,
    input  logic [CELL_W-1:0] wdata,
    output logic [CELL_W-1:0] rdata
);

    logic [CELL_W-1:0] mem [DEPTH];
    logic [CELL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/tce_ctrl.sv @@
// cursor sequencer: item decode, row mapping, blanking sweeps, memory access
module tce_ctrl
    import tce_pkg::*;
#(
    parameter  int ROWS      = 25,
    parameter  int COLS      = 80,
    parameter  int TAB_WIDTH = 8,
    localparam int AW        = $clog2(ROWS * COLS)
) (
    input  logic               clk,
    input  logic               rst_n,
    tce_cmd_if.sink            cmd,
    input  logic [COLOR_W-1:0] fg,
    input  logic [COLOR_W-1:0] bg,
    output logic               res_valid,
    input  logic               res_ready,
    output out_item_t          res,
    output logic               mem_we,
    output logic               mem_re,
    output logic [AW-1:0]      mem_addr,
    output logic [CELL_W-1:0]  mem_wdata,
    input  logic [CELL_W-1:0]  mem_rdata
);

    localparam int ROW_W = $clog2(ROWS);
    localparam int COL_W = $clog2(COLS);
    localparam int PH_W  = $clog2(TAB_WIDTH);
    localparam int TS_W  = $clog2(COLS + TAB_WIDTH + 1);
    // unsigned like the tab limit of the spec, wraps when the tab is wider than a line
    localparam logic [31:0] TAB_LIMIT = 32'(COLS - TAB_WIDTH);

    tce_state_t        state_reg, state_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [PH_W-1:0]   phase_reg, phase_next;
    logic [ROW_W-1:0]  top_reg, top_next;
    logic [ROW_W-1:0]  swp_row_reg, swp_row_next;
    logic [COL_W-1:0]  swp_col_reg, swp_col_next;
    logic [ROW_W-1:0]  swp_end_reg, swp_end_next;
    logic [CELL_W-1:0] cell_reg, cell_next;

    logic              accept;
    logic              rd_in_range;
    logic [ROW_W-1:0]  lrow;
    logic [COL_W-1:0]  lcol;
    logic [ROW_W:0]    prow_sum;
    logic [ROW_W-1:0]  prow;
    logic [ROW_W-1:0]  mrow;
    logic [COL_W-1:0]  mcol;
    logic              at_last_row;
    logic              at_last_col;
    logic [ROW_W-1:0]  top_inc;
    logic [TS_W-1:0]   tab_stop;
    logic [AW-1:0]     idx_full;

    assign accept      = cmd.valid && cmd.ready;
    assign cmd.ready   = (state_reg == S_IDLE);
    assign rd_in_range = (32'(cmd.read_row) < 32'(ROWS)) && (32'(cmd.read_col) < 32'(COLS));
    assign at_last_row = (32'(row_reg) == 32'(ROWS - 1));
    assign at_last_col = (32'(col_reg) == 32'(COLS - 1));
    assign top_inc     = (32'(top_reg) == 32'(ROWS - 1)) ? '0 : top_reg + ROW_W'(1);
    assign tab_stop    = TS_W'(col_reg) + TS_W'(TAB_WIDTH) - TS_W'(phase_reg);

    // logical row to physical row through the scroll offset
    assign lrow     = (cmd.op == OP_READ) ? ROW_W'(cmd.read_row) : row_reg;
    assign lcol     = (cmd.op == OP_READ) ? COL_W'(cmd.read_col) : col_reg;
    assign prow_sum = {1'b0, lrow} + {1'b0, top_reg};
    assign prow     = (32'(prow_sum) >= 32'(ROWS)) ? ROW_W'(32'(prow_sum) - 32'(ROWS))
                                                   : ROW_W'(prow_sum);

    assign mrow     = (state_reg == S_IDLE) ? prow : swp_row_reg;
    assign mcol     = (state_reg == S_IDLE) ? lcol : swp_col_reg;
    assign mem_addr = AW'(mrow) * AW'(COLS) + AW'(mcol);

    assign idx_full = AW'(row_reg) * AW'(COLS) + AW'(col_reg);

    assign res.cell_value   = cell_reg;
    assign res.cursor_row   = OROW_W'(row_reg);
    assign res.cursor_col   = OCOL_W'(col_reg);
    assign res.cursor_index = OIDX_W'(idx_full);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg     <= '0;
            col_reg     <= '0;
            phase_reg   <= '0;
            top_reg     <= '0;
            swp_row_reg <= '0;
            swp_col_reg <= '0;
            swp_end_reg <= ROW_W'(ROWS - 1);
            cell_reg    <= '0;
        end
        else
        begin
            row_reg     <= row_next;
            col_reg     <= col_next;
            phase_reg   <= phase_next;
            top_reg     <= top_next;
            swp_row_reg <= swp_row_next;
            swp_col_reg <= swp_col_next;
            swp_end_reg <= swp_end_next;
            cell_reg    <= cell_next;
        end
    end

    always_comb
    begin
        logic do_nl;

        do_nl        = 1'b0;
        state_next   = state_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        phase_next   = phase_reg;
        top_next     = top_reg;
        swp_row_next = swp_row_reg;
        swp_col_next = swp_col_reg;
        swp_end_next = swp_end_reg;
        cell_next    = cell_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_wdata    = {bg, fg, CH_SPACE};
        res_valid    = 1'b0;

        unique case (state_reg)
            S_INIT, S_SWEEP:
            begin
                mem_we = 1'b1;
                if (state_reg == S_INIT)
                begin
                    mem_wdata = {RESET_BG, RESET_FG, CH_SPACE};
                end
                if (32'(swp_col_reg) == 32'(COLS - 1))
                begin
                    swp_col_next = '0;
                    if (swp_row_reg == swp_end_reg)
                    begin
                        state_next = (state_reg == S_INIT) ? S_IDLE : S_RESULT;
                    end
                    else
                    begin
                        swp_row_next = swp_row_reg + ROW_W'(1);
                    end
                end
                else
                begin
                    swp_col_next = swp_col_reg + COL_W'(1);
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    cell_next  = '0;
                    state_next = S_RESULT;
                    if (cmd.op == OP_READ)
                    begin
                        if (rd_in_range)
                        begin
                            mem_re     = 1'b1;
                            state_next = S_RDWAIT;
                        end
                    end
                    else
                    begin
                        unique case (cmd.char_code)
                            CH_BS:
                            begin
                                if (col_reg != '0)
                                begin
                                    col_next   = col_reg - COL_W'(1);
                                    phase_next = (phase_reg == '0) ? PH_W'(TAB_WIDTH - 1)
                                                                   : phase_reg - PH_W'(1);
                                end
                            end
                            CH_TAB:
                            begin
                                if ((32'(col_reg) < TAB_LIMIT) && (32'(tab_stop) < 32'(COLS)))
                                begin
                                    col_next   = COL_W'(tab_stop);
                                    phase_next = '0;
                                end
                                else
                                begin
                                    do_nl = 1'b1;
                                end
                            end
                            CH_LF:
                            begin
                                do_nl = 1'b1;
                            end
                            CH_CR:
                            begin
                                col_next   = '0;
                                phase_next = '0;
                            end
                            CH_FF:
                            begin
                                // blank every cell in the current colours, home, unscrolled map
                                row_next     = '0;
                                col_next     = '0;
                                phase_next   = '0;
                                top_next     = '0;
                                swp_row_next = '0;
                                swp_col_next = '0;
                                swp_end_next = ROW_W'(ROWS - 1);
                                state_next   = S_SWEEP;
                            end
                            default:
                            begin
                                mem_we    = 1'b1;
                                mem_wdata = {bg, fg, cmd.char_code};
                                if (at_last_col)
                                begin
                                    do_nl = 1'b1;
                                end
                                else
                                begin
                                    col_next   = col_reg + COL_W'(1);
                                    phase_next = (32'(phase_reg) == 32'(TAB_WIDTH - 1))
                                                 ? '0 : phase_reg + PH_W'(1);
                                end
                            end
                        endcase

                        if (do_nl)
                        begin
                            col_next   = '0;
                            phase_next = '0;
                            if (at_last_row)
                            begin
                                // scroll: old top row becomes the blank bottom row
                                top_next     = top_inc;
                                swp_row_next = top_reg;
                                swp_end_next = top_reg;
                                swp_col_next = '0;
                                state_next   = S_SWEEP;
                            end
                            else
                            begin
                                row_next = row_reg + ROW_W'(1);
                            end
                        end
                    end
                end
            end

            S_RDWAIT:
            begin
                cell_next  = mem_rdata;
                state_next = S_RESULT;
            end

            S_RESULT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(col_reg) < 32'(COLS)) && (32'(row_reg) < 32'(ROWS)) && (32'(top_reg) < 32'(ROWS)))
        else $error("cursor or scroll offset out of range");

    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_INIT || state_reg == S_SWEEP ||
                    (accept && cmd.op == OP_PUT)))
        else $error("cell write outside a sweep or a put");

    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RDWAIT) |-> $past(mem_re))
        else $error("read data taken without a read issued");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !cmd.ready)
        else $error("second item taken while one is at work");
`endif

endmodule

@@ hw/rtl/text_console_engine_top.sv @@
// top level of the text console engine: register file, sequencer, screen memory, result register
//
//  channel | dir | payload                                            | transfer when
//  cmd     | in  | op, char_code, read_row, read_col                  | cmd.valid & cmd.ready
//  rsp     | out | cell_value, cursor_row, cursor_col, cursor_index   | rsp.valid & rsp.ready
//  cfg     | in  | index (0 fg_color, 1 bg_color), data               | cfg.valid & cfg.ready
//
// a read passes through S_RDWAIT to S_RESULT, an ordinary put goes straight to S_RESULT; a put
// that scrolls first blanks one line, a form feed the whole screen, one cell per cycle
// through the single memory write port
// scrolling rotates a row offset instead of moving cells, so only the new bottom line is written
// after reset the memory is swept to blank cells, during which cmd is not ready;
// cfg is always ready
// the result register holds one finished item, so the next command is taken while rsp stalls
module text_console_engine_top
    import tce_pkg::*;
#(
    parameter int ROWS      = 25,
    parameter int COLS      = 80,
    parameter int TAB_WIDTH = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    tce_cmd_if.sink   cmd,
    tce_rsp_if.source rsp,
    tce_cfg_if.sink   cfg
);

    localparam int DEPTH = ROWS * COLS;
    localparam int AW    = $clog2(DEPTH);

    // colour registers
    logic [COLOR_W-1:0] fg_reg;
    logic [COLOR_W-1:0] bg_reg;

    // result register
    logic      out_valid_reg;
    out_item_t out_item_reg;

    // sequencer to result register
    logic      res_valid;
    logic      res_ready;
    out_item_t res;

    // sequencer to memory
    logic              mem_we;
    logic              mem_re;
    logic [AW-1:0]     mem_addr;
    logic [CELL_W-1:0] mem_wdata;
    logic [CELL_W-1:0] mem_rdata;

    assign cfg.ready = 1'b1;

    // register writes, indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg <= RESET_FG;
            bg_reg <= RESET_BG;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_FG_IDX: fg_reg <= cfg.data;
                CFG_BG_IDX: bg_reg <= cfg.data;
                default:    ;
            endcase
        end
    end

    tce_ctrl #(
        .ROWS      (ROWS),
        .COLS      (COLS),
        .TAB_WIDTH (TAB_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .fg        (fg_reg),
        .bg        (bg_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_re    (mem_re),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    tce_screen_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // result slot is free when empty or being emptied this cycle
    assign res_ready = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_item_reg <= res;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.cell_value   = out_item_reg.cell_value;
    assign rsp.cursor_row   = out_item_reg.cursor_row;
    assign rsp.cursor_col   = out_item_reg.cursor_col;
    assign rsp.cursor_index = out_item_reg.cursor_index;

endmodule

@@ sim/tb_text_console_engine_top.sv @@
// self-checking testbench of the text console engine: directed and random traffic
`timescale 1ns / 1ps

module tb_text_console_engine_top;
    import tce_pkg::*;

    localparam int ROWS          = 25;
    localparam int COLS          = 80;
    localparam int TAB_WIDTH     = 8;
    localparam int CELLS         = ROWS * COLS;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS   = 185;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 8;
    // a run of nothing but form feeds under the longest stalls, each one sweeping
    // every cell, still stays several times below this bound
    localparam int CYCLE_LIMIT   = 8_000_000;

    // mirror of the console: screen, cursor and colors, plus the reports it
    // predicts for every accepted command
    class console_mirror;
        logic [CELL_W-1:0] shadow_cells [CELLS];
        int                row_pos;
        int                col_pos;
        logic [COLOR_W-1:0] fg_nib;
        logic [COLOR_W-1:0] bg_nib;
        out_item_t         screen_reports [$];
        int                errors;
        int                checked;
        int                puts;
        int                reads;
        int                scrolls;
        int                clears;

        function new();
            fg_nib = RESET_FG;
            bg_nib = RESET_BG;
            clear_all();
            errors  = 0;
            checked = 0;
            puts    = 0;
            reads   = 0;
            scrolls = 0;
            clears  = 0;
        endfunction

        function logic [CELL_W-1:0] colour_cell(input logic [CHAR_W-1:0] ch);
            return {bg_nib, fg_nib, ch};
        endfunction

        function void clear_all();
            for (int i = 0; i < CELLS; i++)
                shadow_cells[i] = colour_cell(CH_SPACE);
            row_pos = 0;
            col_pos = 0;
        endfunction

        // cursor move with line wrap and scroll below the last row
        function void place(input int r, input int c);
            if (c > COLS - 1) begin
                r = r + 1;
                c = 0;
            end
            if (r > ROWS - 1) begin
                r = ROWS - 1;
                c = 0;
                for (int i = 0; i < (ROWS - 1) * COLS; i++)
                    shadow_cells[i] = shadow_cells[i + COLS];
                for (int i = (ROWS - 1) * COLS; i < CELLS; i++)
                    shadow_cells[i] = colour_cell(CH_SPACE);
                scrolls++;
            end
            row_pos = r;
            col_pos = c;
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] val);
            if (idx == CFG_FG_IDX)
                fg_nib = val;
            else if (idx == CFG_BG_IDX)
                bg_nib = val;
        endfunction

        function void apply_command(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                                    input logic [RROW_W-1:0] rr, input logic [RCOL_W-1:0] rc);
            out_item_t         rep;
            logic [CELL_W-1:0] cell_val;
            cell_val = '0;
            if (op == OP_PUT) begin
                puts++;
                case (ch)
                    CH_BS:
                        if (col_pos != 0)
                            place(row_pos, col_pos - 1);
                    CH_TAB:
                        if (col_pos < COLS - TAB_WIDTH)
                            place(row_pos, (col_pos / TAB_WIDTH + 1) * TAB_WIDTH);
                        else
                            place(row_pos + 1, 0);
                    CH_LF:
                        place(row_pos + 1, 0);
                    CH_FF:
                    begin
                        clear_all();
                        clears++;
                    end
                    CH_CR:
                        place(row_pos, 0);
                    default:
                    begin
                        shadow_cells[row_pos * COLS + col_pos] = colour_cell(ch);
                        place(row_pos, col_pos + 1);
                    end
                endcase
            end else begin
                reads++;
                if (int'(rr) < ROWS && int'(rc) < COLS)
                    cell_val = shadow_cells[int'(rr) * COLS + int'(rc)];
            end
            rep.cell_value   = cell_val;
            rep.cursor_row   = OROW_W'(row_pos);
            rep.cursor_col   = OCOL_W'(col_pos);
            rep.cursor_index = OIDX_W'(row_pos * COLS + col_pos);
            screen_reports.push_back(rep);
        endfunction

        function void compare_report(input out_item_t got);
            out_item_t want;
            if (screen_reports.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected report: cell %h row %0d col %0d idx %0d",
                             got.cell_value, got.cursor_row, got.cursor_col, got.cursor_index);
                return;
            end
            want = screen_reports.pop_front();
            checked++;
            if (got.cell_value !== want.cell_value || got.cursor_row !== want.cursor_row ||
                got.cursor_col !== want.cursor_col || got.cursor_index !== want.cursor_index)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("report %0d: expected cell %h row %0d col %0d idx %0d",
                             checked, want.cell_value, want.cursor_row, want.cursor_col,
                             want.cursor_index);
                    $display("report %0d: got      cell %h row %0d col %0d idx %0d",
                             checked, got.cell_value, got.cursor_row, got.cursor_col,
                             got.cursor_index);
                end
            end
        endfunction

        function int pending();
            return screen_reports.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    tce_cmd_if cmd_if ();
    tce_rsp_if rsp_if ();
    tce_cfg_if cfg_if ();

    text_console_engine_top #(
        .ROWS      (ROWS),
        .COLS      (COLS),
        .TAB_WIDTH (TAB_WIDTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    console_mirror mirror = new();

    // idle bursts on both sides are enabled by idle_on; long_hold_req asks the
    // response side for one long stall
    bit          idle_on       = 1'b1;
    bit          long_hold_req = 1'b0;
    int unsigned cycle_count   = 0;
    int          settings_used = 1;

    // 4 ns clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // watchdog: a hung block ends the run here
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("text_console_engine_top: mismatch");
        $finish;
    end

    // every transfer is sampled at the edge that completes it; pre-edge values
    // are seen since all drivers use nonblocking assignments
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (cfg_if.valid && cfg_if.ready)
                mirror.set_reg(cfg_if.index, cfg_if.data);
            if (cmd_if.valid && cmd_if.ready)
                mirror.apply_command(cmd_if.op, cmd_if.char_code, cmd_if.read_row,
                                     cmd_if.read_col);
            if (rsp_if.valid && rsp_if.ready)
                mirror.compare_report('{cell_value:   rsp_if.cell_value,
                                        cursor_row:   rsp_if.cursor_row,
                                        cursor_col:   rsp_if.cursor_col,
                                        cursor_index: rsp_if.cursor_index});
        end
    end

    // response side: random stall bursts, plus one long hold-off on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (stall_left > 0) begin
                rsp_if.ready <= 1'b0;
                stall_left--;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left = LONG_HOLD - 1;
                rsp_if.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 8) - 1;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // one command transfer; valid stays high afterwards so that back-to-back
    // commands need no extra edge
    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                            input logic [RROW_W-1:0] rr, input logic [RCOL_W-1:0] rc);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_if.valid     <= 1'b1;
        cmd_if.op        <= op;
        cmd_if.char_code <= ch;
        cmd_if.read_row  <= rr;
        cmd_if.read_col  <= rc;
        do
            @(posedge clk);
        while (!cmd_if.ready);
    endtask

    // a put with don't-care read coordinates, randomized for bit coverage
    task automatic put(input logic [CHAR_W-1:0] ch);
        send_cmd(OP_PUT, ch, RROW_W'($urandom_range(0, 31)), RCOL_W'($urandom_range(0, 127)));
    endtask

    task automatic read_cell(input logic [RROW_W-1:0] rr, input logic [RCOL_W-1:0] rc);
        send_cmd(OP_READ, CHAR_W'($urandom_range(0, 255)), rr, rc);
    endtask

    // only called with the block idle
    task automatic set_colours(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= CFG_FG_IDX;
        cfg_if.data  <= fg;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.index <= CFG_BG_IDX;
        cfg_if.data  <= bg;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        settings_used++;
    endtask

    // stop offering commands and let every outstanding report come back
    task automatic drain();
        cmd_if.valid <= 1'b0;
        while (mirror.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one random command; lf_weight biases toward newlines so that scrolling
    // is reached often
    task automatic random_cmd(input int lf_weight);
        int pick;
        int sel;
        pick = $urandom_range(0, 99);
        if (pick < 28) begin
            sel = $urandom_range(0, 9);
            if (sel == 0)
                // anything the fields allow, out of range included
                read_cell(RROW_W'($urandom_range(0, 31)), RCOL_W'($urandom_range(0, 127)));
            else if (sel < 4)
                // the cursor row holds the freshest text
                read_cell(RROW_W'(mirror.row_pos), RCOL_W'($urandom_range(0, COLS - 1)));
            else
                read_cell(RROW_W'($urandom_range(0, ROWS - 1)),
                          RCOL_W'($urandom_range(0, COLS - 1)));
        end else begin
            sel = $urandom_range(0, 199);
            if (sel == 0)
                put(CH_FF);
            else if (sel < 1 + lf_weight)
                put(CH_LF);
            else if (sel < 21 + lf_weight)
                put(CH_TAB);
            else if (sel < 37 + lf_weight)
                put(CH_BS);
            else if (sel < 47 + lf_weight)
                put(CH_CR);
            else if (sel < 120)
                put(CHAR_W'($urandom_range(0, 255)));
            else
                put(CHAR_W'($urandom_range(8'h21, 8'h7E)));
        end
    endtask

    initial
    begin
        logic [COLOR_W-1:0] fg_plan [RANDOM_PHASES];
        logic [COLOR_W-1:0] bg_plan [RANDOM_PHASES];
        int                 lf_plan [RANDOM_PHASES];

        // color settings per phase, extremes first
        fg_plan = '{4'd0, 4'd15, 4'd15, 4'd0, COLOR_W'($urandom_range(0, 15))};
        bg_plan = '{4'd0, 4'd15, 4'd0, 4'd15, COLOR_W'($urandom_range(0, 15))};
        lf_plan = '{20, 60, 25, 30, 20};

        rst_n            <= 1'b0;
        cmd_if.valid     <= 1'b0;
        cmd_if.op        <= OP_PUT;
        cmd_if.char_code <= '0;
        cmd_if.read_row  <= '0;
        cmd_if.read_col  <= '0;
        cfg_if.valid     <= 1'b0;
        cfg_if.index     <= CFG_FG_IDX;
        cfg_if.data      <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part in the reset colors; the block holds off commands
        // during its clearing sweep
        read_cell(5'd0, 7'd0);                 // blank cell after reset
        put(CH_BS);                            // backspace at column 0 is a no-op
        put(8'h41);
        put(8'h00);
        put(8'hFF);
        put(CH_BS);
        put(CH_CR);
        read_cell(5'd0, 7'd0);
        read_cell(5'd0, 7'd1);
        read_cell(5'd24, 7'd79);               // last cell
        read_cell(5'd31, 7'd127);              // both coordinates out of range
        read_cell(5'd25, 7'd0);                // first row past the screen
        read_cell(5'd0, 7'd80);                // first column past the line
        repeat (9) put(CH_TAB);                // tab stops up to the last one
        put(CH_TAB);                           // tab near the line end wraps
        put(CH_LF);
        put(CH_FF);
        drain();

        // random phases, one color setting each; the last one runs without
        // idling, the third carries the long response stall
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            set_colours(fg_plan[ph], bg_plan[ph]);
            idle_on = (ph != RANDOM_PHASES - 1);
            if (ph == 2)
                long_hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                random_cmd(lf_plan[ph]);
            drain();
        end

        $display("covered %0d puts (%0d scrolls, %0d clears), %0d reads, %0d color settings",
                 mirror.puts, mirror.scrolls, mirror.clears, mirror.reads, settings_used);
        $display("%0d reports checked, %0d mismatches", mirror.checked, mirror.errors);
        if (mirror.errors == 0 && mirror.pending() == 0)
            $display("text_console_engine_top: match");
        else
            $display("text_console_engine_top: mismatch");
        $finish;
    end

endmodule
